### hdl/stg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stg_pkg;

   // Phase accumulator and sine table geometry.
   localparam int SINE_TABLE_BITS = 10;
   localparam int PHASE_BITS      = 32;
   localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
   localparam int QUARTER         = 1 << QUARTER_BITS;
   localparam int LUT_ADDR_BITS   = QUARTER_BITS + 1;

   // Field widths of the stream payloads.
   localparam int MODE_BITS   = 2;
   localparam int FREQ_BITS   = 15;
   localparam int MS_BITS     = 16;
   localparam int AMP_BITS    = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int STATUS_BITS = 2;
   localparam int RATE_BITS   = 16;
   localparam int FRAME_BITS  = 32;
   localparam int MAG_BITS    = 15;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 32;
   localparam int RSP_USER_BITS = 1 + STATUS_BITS;
   localparam int CSR_INDEX_BITS = 2;

   // Shared divider width: holds either the frame product or freq shifted by the phase width.
   localparam int DIV_BITS = (FREQ_BITS + PHASE_BITS > FRAME_BITS) ?
                             (FREQ_BITS + PHASE_BITS) : FRAME_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

   localparam logic [RATE_BITS-1:0] MS_PER_S = 16'd1000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] FULL_SCALE  = 64'd32767;

   // Burst length: floor(p / 1000) equals (p * MS_RECIP) >> MS_RECIP_SHIFT for any 32-bit p.
   localparam int MS_RECIP_BITS  = 29;
   localparam int MS_RECIP_SHIFT = 38;
   localparam logic [MS_RECIP_BITS-1:0] MS_RECIP =
      MS_RECIP_BITS'(((64'd1 << MS_RECIP_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));

   // Input modes.
   localparam logic [MODE_BITS-1:0] MODE_TONE    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SILENCE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_TICK    = 2'd2;

   // Command classes passed from the front to the back.
   localparam logic [1:0] CMD_REJECT  = 2'd0;
   localparam logic [1:0] CMD_TONE    = 2'd1;
   localparam logic [1:0] CMD_SILENCE = 2'd2;
   localparam logic [1:0] CMD_TICK    = 2'd3;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_REJECTED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_IDLE     = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_RATE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEREO   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE   = 2'd2;
   localparam logic [RATE_BITS-1:0] OUT_RATE_RESET = 16'd24000;

   typedef struct packed {
      logic [RATE_BITS-1:0] out_rate_hz;
      logic                 stereo_output;
      logic                 output_enabled;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [FREQ_BITS-1:0] freq;
      logic [MS_BITS-1:0]   ms;
      logic [AMP_BITS-1:0]  amp;
   } cmd_type;

   typedef logic [MAG_BITS-1:0] lut_type [0:QUARTER];

   // Quarter-wave entry k: Taylor sum of degree 11 in Q30, scaled to full scale and rounded.
   function automatic logic [MAG_BITS-1:0] quarter_sine(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x = (64'(k) * HALF_PI_Q30) >> QUARTER_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      term = ((term * x2) >> 30) / 6;
      sum = sum - term;
      term = ((term * x2) >> 30) / 20;
      sum = sum + term;
      term = ((term * x2) >> 30) / 42;
      sum = sum - term;
      term = ((term * x2) >> 30) / 72;
      sum = sum + term;
      term = ((term * x2) >> 30) / 110;
      sum = sum - term;
      return MAG_BITS'((sum * FULL_SCALE + (64'd1 << 29)) >> 30);
   endfunction

   function automatic lut_type build_sine_lut();
      lut_type lut;
      for (int i = 0; i <= QUARTER; i++) begin
         lut[i] = quarter_sine(i);
      end
      return lut;
   endfunction

   localparam lut_type SINE_LUT = build_sine_lut();

endpackage
`default_nettype wire

### hdl/stg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module stg_front (
   input  wire logic                                 reset,
   input  wire stg_pkg::cfg_type                     cfg,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [stg_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  wire logic [stg_pkg::MODE_BITS-1:0]        req_tuser,
   input  wire logic                                 queue_full,
   output logic                                      queue_push,
   output stg_pkg::cmd_type                          queue_data
);
   import stg_pkg::*;

   logic [FREQ_BITS-1:0] freq;
   logic [MS_BITS-1:0]   ms;
   logic [AMP_BITS-1:0]  amp;

   // Unpack the request payload.
   assign freq = req_tdata[FREQ_BITS-1:0];
   assign ms   = req_tdata[FREQ_BITS+MS_BITS-1:FREQ_BITS];
   assign amp  = req_tdata[FREQ_BITS+MS_BITS+AMP_BITS-1:FREQ_BITS+MS_BITS];

   // A transaction is taken whenever the queue has room and reset is low.
   assign req_tready = !queue_full && !reset;
   assign queue_push = req_tvalid && req_tready;

   // Classify the command; invalid starts and the unused mode become rejects.
   always_comb begin
      queue_data.freq = freq;
      queue_data.ms   = ms;
      queue_data.amp  = amp;
      case (req_tuser)
         MODE_TONE: begin
            if (!cfg.output_enabled || freq == '0 || ms == '0 || cfg.out_rate_hz == '0) begin
               queue_data.kind = CMD_REJECT;
            end else begin
               queue_data.kind = CMD_TONE;
            end
         end
         MODE_SILENCE: begin
            if (!cfg.output_enabled || ms == '0) begin
               queue_data.kind = CMD_REJECT;
            end else begin
               queue_data.kind = CMD_SILENCE;
            end
         end
         MODE_TICK: queue_data.kind = CMD_TICK;
         default:   queue_data.kind = CMD_REJECT;
      endcase
   end

endmodule
`default_nettype wire

### hdl/stg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module stg_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire stg_pkg::cmd_type push_data,
   input  wire logic             pop,
   output stg_pkg::cmd_type      pop_data,
   output logic                  full,
   output logic                  empty
);
   import stg_pkg::*;

   cmd_type entry_ff [0:1];
   logic    wr_ptr_ff;
   logic    wr_ptr_in;
   logic    rd_ptr_ff;
   logic    rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### hdl/stg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module stg_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire stg_pkg::cfg_type                     cfg,
   input  wire logic                                 queue_empty,
   input  wire stg_pkg::cmd_type                     queue_data,
   output logic                                      queue_pop,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [stg_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   output logic                                      rsp_tlast,
   output logic [stg_pkg::RSP_USER_BITS-1:0]         rsp_tuser
);
   import stg_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_FRAMES   = 3'd1;
   localparam logic [2:0] ST_DIV_STEP = 3'd2;
   localparam logic [2:0] ST_SCALE    = 3'd3;
   localparam logic [2:0] ST_ROUND    = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [PHASE_BITS-1:0]  phase_accum_ff, phase_accum_in;
   logic [PHASE_BITS-1:0]  phase_step_ff, phase_step_in;
   logic [FRAME_BITS-1:0]  frames_left_ff, frames_left_in;
   logic [AMP_BITS-1:0]    gain_ff, gain_in;
   logic                   silent_ff, silent_in;
   logic                   tone_ff, tone_in;
   logic [FREQ_BITS-1:0]   freq_ff, freq_in;
   logic [AMP_BITS-1:0]    amp_ff, amp_in;
   logic [DIV_BITS-1:0]    div_q_ff, div_q_in;
   logic [RATE_BITS-1:0]   div_r_ff, div_r_in;
   logic [RATE_BITS-1:0]   div_d_ff, div_d_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic [MAG_BITS-1:0]    lut_ff, lut_in;
   logic                   neg_ff, neg_in;
   logic                   last_ff, last_in;
   logic [MAG_BITS+AMP_BITS-1:0] prod_ff, prod_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic [SAMPLE_BITS-1:0] rsp_right_ff, rsp_right_in;
   logic                   rsp_frame_ff, rsp_frame_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   logic                   go;
   logic [RATE_BITS:0]     rem_shift;
   logic                   rem_ge;
   logic [RATE_BITS:0]     rem_next;
   logic [DIV_BITS-1:0]    quot_next;
   logic [SINE_TABLE_BITS-1:0] lut_idx;
   logic [QUARTER_BITS-1:0]    lut_k;
   logic [LUT_ADDR_BITS-1:0]   lut_addr;
   logic [FRAME_BITS-1:0]  frame_product;
   logic [FRAME_BITS+MS_RECIP_BITS-1:0] frames_wide;
   logic [FRAME_BITS-1:0]  frames_quot;
   logic [FRAME_BITS-1:0]  frames_dec;
   logic [AMP_BITS-1:0]    mag_raw;
   logic [MAG_BITS-1:0]    mag;
   logic [SAMPLE_BITS-1:0] sample;

   // One restoring divider step a cycle.
   assign rem_shift = {div_r_ff, div_q_ff[DIV_BITS-1]};
   assign rem_ge    = rem_shift >= {1'b0, div_d_ff};
   assign rem_next  = rem_ge ? (rem_shift - {1'b0, div_d_ff}) : rem_shift;
   assign quot_next = {div_q_ff[DIV_BITS-2:0], rem_ge};

   // Quarter-wave table address from the top phase bits.
   assign lut_idx  = phase_accum_ff[PHASE_BITS-1 -: SINE_TABLE_BITS];
   assign lut_k    = lut_idx[QUARTER_BITS-1:0];
   assign lut_addr = lut_idx[QUARTER_BITS] ?
                     (LUT_ADDR_BITS'(QUARTER) - {1'b0, lut_k}) : {1'b0, lut_k};

   assign frame_product = FRAME_BITS'(cfg.out_rate_hz) * FRAME_BITS'(queue_data.ms);
   assign frames_dec    = frames_left_ff - 1'b1;

   // Burst length from the registered frame product by a reciprocal multiply.
   assign frames_wide = (FRAME_BITS+MS_RECIP_BITS)'(div_q_ff[FRAME_BITS-1:0]) *
                        (FRAME_BITS+MS_RECIP_BITS)'(MS_RECIP);
   assign frames_quot = FRAME_BITS'(frames_wide[FRAME_BITS+MS_RECIP_BITS-1:MS_RECIP_SHIFT]);

   // Gain scaling with clamp to full scale.
   assign mag_raw = prod_ff[MAG_BITS+AMP_BITS-1:MAG_BITS];
   assign mag     = mag_raw[AMP_BITS-1] ? {MAG_BITS{1'b1}} : mag_raw[MAG_BITS-1:0];
   assign sample  = neg_ff ? SAMPLE_BITS'(-{1'b0, mag}) : {1'b0, mag};

   // A command is taken only when the result register is free by the next edge.
   assign go        = (state_ff == ST_IDLE) && !queue_empty && (!rsp_valid_ff || rsp_tready);
   assign queue_pop = go;

   // Command sequencer.
   always_comb begin
      state_in       = state_ff;
      phase_accum_in = phase_accum_ff;
      phase_step_in  = phase_step_ff;
      frames_left_in = frames_left_ff;
      gain_in        = gain_ff;
      silent_in      = silent_ff;
      tone_in        = tone_ff;
      freq_in        = freq_ff;
      amp_in         = amp_ff;
      div_q_in       = div_q_ff;
      div_r_in       = div_r_ff;
      div_d_in       = div_d_ff;
      div_cnt_in     = div_cnt_ff;
      lut_in         = lut_ff;
      neg_in         = neg_ff;
      last_in        = last_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_left_in    = rsp_left_ff;
      rsp_right_in   = rsp_right_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               case (queue_data.kind)
                  CMD_TONE, CMD_SILENCE: begin
                     // Burst length first: rate * ms / 1000.
                     tone_in  = queue_data.kind == CMD_TONE;
                     freq_in  = queue_data.freq;
                     amp_in   = queue_data.amp;
                     div_q_in = DIV_BITS'(frame_product);
                     state_in = ST_FRAMES;
                  end
                  CMD_TICK: begin
                     if (frames_left_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_left_in   = '0;
                        rsp_right_in  = '0;
                        rsp_frame_in  = 1'b0;
                        rsp_last_in   = 1'b0;
                        rsp_status_in = STATUS_IDLE;
                     end else if (silent_ff) begin
                        frames_left_in = frames_dec;
                        rsp_valid_in   = 1'b1;
                        rsp_left_in    = '0;
                        rsp_right_in   = '0;
                        rsp_frame_in   = 1'b1;
                        rsp_last_in    = frames_dec == '0;
                        rsp_status_in  = STATUS_OK;
                     end else begin
                        lut_in         = SINE_LUT[lut_addr];
                        neg_in         = lut_idx[SINE_TABLE_BITS-1];
                        last_in        = frames_dec == '0;
                        frames_left_in = frames_dec;
                        phase_accum_in = phase_accum_ff + phase_step_ff;
                        state_in       = ST_SCALE;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_left_in   = '0;
                     rsp_right_in  = '0;
                     rsp_frame_in  = 1'b0;
                     rsp_last_in   = 1'b0;
                     rsp_status_in = STATUS_REJECTED;
                  end
               endcase
            end
         end
         ST_FRAMES: begin
            frames_left_in = frames_quot;
            if (tone_ff) begin
               // Phase step next: freq * 2^PHASE_BITS / rate.
               div_q_in   = DIV_BITS'({freq_ff, {PHASE_BITS{1'b0}}});
               div_r_in   = '0;
               div_d_in   = cfg.out_rate_hz;
               div_cnt_in = DIV_CNT_BITS'(DIV_BITS);
               state_in   = ST_DIV_STEP;
            end else begin
               silent_in     = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_left_in   = '0;
               rsp_right_in  = '0;
               rsp_frame_in  = 1'b0;
               rsp_last_in   = 1'b0;
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         ST_DIV_STEP: begin
            div_q_in   = quot_next;
            div_r_in   = rem_next[RATE_BITS-1:0];
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == DIV_CNT_BITS'(1)) begin
               phase_step_in  = quot_next[PHASE_BITS-1:0];
               phase_accum_in = '0;
               gain_in        = amp_ff;
               silent_in      = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_left_in    = '0;
               rsp_right_in   = '0;
               rsp_frame_in   = 1'b0;
               rsp_last_in    = 1'b0;
               rsp_status_in  = STATUS_OK;
               state_in       = ST_IDLE;
            end
         end
         ST_SCALE: begin
            prod_in  = (MAG_BITS+AMP_BITS)'(lut_ff) * (MAG_BITS+AMP_BITS)'(gain_ff);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            rsp_valid_in  = 1'b1;
            rsp_left_in   = sample;
            rsp_right_in  = cfg.stereo_output ? sample : '0;
            rsp_frame_in  = 1'b1;
            rsp_last_in   = last_ff;
            rsp_status_in = STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and the burst state of the model.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_accum_ff <= '0;
         phase_step_ff  <= '0;
         frames_left_ff <= '0;
         gain_ff        <= '0;
         silent_ff      <= 1'b0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_accum_ff <= phase_accum_in;
         phase_step_ff  <= phase_step_in;
         frames_left_ff <= frames_left_in;
         gain_ff        <= gain_in;
         silent_ff      <= silent_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      tone_ff       <= tone_in;
      freq_ff       <= freq_in;
      amp_ff        <= amp_in;
      div_q_ff      <= div_q_in;
      div_r_ff      <= div_r_in;
      div_d_ff      <= div_d_in;
      lut_ff        <= lut_in;
      neg_ff        <= neg_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_right_ff, rsp_left_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_frame_ff};

endmodule
`default_nettype wire

### hdl/sine_tone_burst_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Sine tone burst generator (direct digital synthesis).
// The req_ channel takes commands: start tone, start silence, or a sample tick.
// The rsp_ channel returns exactly one result transaction for every command:
// a status for starts and idle ticks, one audio frame (left, right) for other ticks.
// The csr_ port writes sample rate, stereo and output enable; write only while idle.
// A small command queue sits between the accepting front and the executing back,
// so requests are still taken while a result waits for the receiver.
// An accepted command waits in the queue until the back takes it. A tone tick then
// passes a table read, a gain multiply and a clamp; the back takes no new command
// until its frame is registered. Silent ticks, idle ticks and rejected starts are
// answered directly in idle. A silence start gets its burst length by a reciprocal
// multiply, and a tone start adds the one-bit-per-cycle phase step divider.
// Reset is synchronous and active high: it clears the burst state, empties the
// queue and loads sample rate 24000 with stereo and output disabled.
// When the receiver stalls, the result register holds; the queue then fills and
// req_tready drops once two commands wait in it.
module sine_tone_burst_generator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // Fields from bit 0: tone_freq_hz[14:0], burst_ms[30:15], amplitude_q15[46:31].
   input  wire logic [stg_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // Fields from bit 0: mode[1:0].
   input  wire logic [stg_pkg::MODE_BITS-1:0]        req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // Fields from bit 0: left_sample[15:0], right_sample[31:16].
   output logic [stg_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   // The burst_last field.
   output logic                                      rsp_tlast,
   // Fields from bit 0: frame_valid[0], status[2:1].
   output logic [stg_pkg::RSP_USER_BITS-1:0]         rsp_tuser,
   input  wire logic                                 csr_we,
   input  wire logic [stg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [stg_pkg::RATE_BITS-1:0]        csr_wdata
);
   import stg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    queue_full;
   logic    queue_empty;
   logic    queue_push;
   logic    queue_pop;
   cmd_type push_data;
   cmd_type pop_data;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OUT_RATE: cfg_in.out_rate_hz    = csr_wdata;
            CSR_STEREO:   cfg_in.stereo_output  = csr_wdata[0];
            CSR_ENABLE:   cfg_in.output_enabled = csr_wdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_rate_hz    <= OUT_RATE_RESET;
         cfg_ff.stereo_output  <= 1'b0;
         cfg_ff.output_enabled <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stg_front u_front (
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (push_data)
   );

   stg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   stg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_data  (pop_data),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire
